>>> hdl/fqsr_pkg.sv
package fqsr_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_EMPTY   = 2'd2,
        STAT_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] popped_value;
        logic               found;
        logic [3:0]         match_position;
        logic [4:0]         entry_count;
    } t_out;

    // per-cell control: shift toward the head, and/or load from the broadcast bus
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

>>> hdl/fifo_queue_with_search_and_remove_core.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_stall    i_in_data  (t_in)
// out       output     o_out_valid / i_out_stall  o_out_data (t_out)
//
// Push, pop, and search or remove on an empty queue are answered without a sweep.
// Search and remove rotate the cell chain once through the held entries,
// comparing the head cell each cycle; input is stalled until the result is loaded.
// Reset clears the occupancy and control state; cell contents are left as is.
// A stalled result is held in the output register; input is stalled until it can
// take the next result.
module fifo_queue_with_search_and_remove_core
    import fqsr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int OCW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic [OCW-1:0]    r_occ;
    logic [OCW-1:0]    r_left;
    logic [OCW-1:0]    r_k;
    logic [OCW-1:0]    r_pos;
    logic              r_found;
    logic              r_is_rm;
    logic [DATA_W-1:0] r_key;
    logic              r_out_valid;
    t_out              r_out;

    logic [DATA_W-1:0] w_cell_q [DEPTH];
    logic [DATA_W-1:0] w_head;
    logic              w_can_load;
    logic              w_in_acc;
    logic              w_full;
    logic              w_empty;
    logic              w_sweep;
    logic              w_hit;
    logic              w_drop;
    logic              w_push_ok;
    logic              w_pop_ok;
    logic              w_shift;
    logic              w_load_en;
    logic [OCW-1:0]    w_load_pos;
    logic [DATA_W-1:0] w_load_data;
    logic              w_out_load;

    function automatic logic [4:0] cnt5(input logic [OCW-1:0] v);
        logic [OCW+4:0] t;
        t = {5'b0, v};
        return t[4:0];
    endfunction

    function automatic logic [3:0] pos4(input logic [OCW-1:0] v);
        logic [OCW+3:0] t;
        t = {4'b0, v};
        return t[3:0];
    endfunction

    assign w_head     = w_cell_q[0];
    assign w_can_load = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_can_load;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_occ == OCW'(DEPTH));
    assign w_empty    = (r_occ == '0);

    assign w_sweep   = (r_state == S_SWEEP);
    assign w_hit     = w_sweep && !r_found && (w_head == r_key);
    assign w_drop    = w_hit && r_is_rm;
    assign w_push_ok = w_in_acc && (i_in_data.cmd == CMD_PUSH) && !w_full;
    assign w_pop_ok  = w_in_acc && (i_in_data.cmd == CMD_POP) && !w_empty;

    // a result is loaded straight away unless a sweep is needed first
    assign w_out_load = (w_in_acc && ((i_in_data.cmd == CMD_PUSH) ||
                                      (i_in_data.cmd == CMD_POP) || w_empty)) ||
                        ((r_state == S_FINISH) && w_can_load);

    // during a sweep every entry but a removed one goes round to the tail
    assign w_shift     = w_pop_ok || w_sweep;
    assign w_load_en   = w_push_ok || (w_sweep && !w_drop);
    assign w_load_pos  = w_push_ok ? r_occ : (r_occ - OCW'(1));
    assign w_load_data = w_push_ok ? $unsigned(i_in_data.value) : w_head;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctrl        w_ctrl;
        logic [DATA_W-1:0] w_next;

        assign w_ctrl.shift = w_shift;
        assign w_ctrl.load  = w_load_en && (w_load_pos == OCW'(gi));

        if (gi == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_q[gi+1];
        end

        fqsr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_load_data (w_load_data),
            .i_next_data (w_next),
            .o_data      (w_cell_q[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_is_rm     <= 1'b0;
            r_left      <= '0;
            r_k         <= '0;
            r_pos       <= '0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_out.found          <= 1'b0;
                        r_out.match_position <= '0;
                        case (i_in_data.cmd)
                            CMD_PUSH: begin
                                r_out.popped_value <= '0;
                                if (w_full) begin
                                    r_out.status      <= STAT_FULL;
                                    r_out.entry_count <= cnt5(r_occ);
                                end else begin
                                    r_occ             <= r_occ + OCW'(1);
                                    r_out.status      <= STAT_OK;
                                    r_out.entry_count <= cnt5(r_occ + OCW'(1));
                                end
                            end
                            CMD_POP: begin
                                if (w_empty) begin
                                    r_out.status       <= STAT_EMPTY;
                                    r_out.popped_value <= '0;
                                    r_out.entry_count  <= cnt5(r_occ);
                                end else begin
                                    r_occ              <= r_occ - OCW'(1);
                                    r_out.status       <= STAT_OK;
                                    r_out.popped_value <= $signed(w_head);
                                    r_out.entry_count  <= cnt5(r_occ - OCW'(1));
                                end
                            end
                            default: begin
                                if (w_empty) begin
                                    r_out.status       <= STAT_MISSING;
                                    r_out.popped_value <= '0;
                                    r_out.entry_count  <= cnt5(r_occ);
                                end else begin
                                    r_key   <= $unsigned(i_in_data.value);
                                    r_is_rm <= (i_in_data.cmd == CMD_REMOVE);
                                    r_left  <= r_occ;
                                    r_k     <= '0;
                                    r_pos   <= '0;
                                    r_found <= 1'b0;
                                    r_state <= S_SWEEP;
                                end
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_pos   <= r_k;
                    end
                    if (w_drop) begin
                        r_occ <= r_occ - OCW'(1);
                    end
                    r_left <= r_left - OCW'(1);
                    r_k    <= r_k + OCW'(1);
                    if (r_left == OCW'(1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_can_load) begin
                        r_out.status         <= r_found ? STAT_OK : STAT_MISSING;
                        r_out.popped_value   <= '0;
                        r_out.found          <= r_found;
                        r_out.match_position <= pos4(r_pos);
                        r_out.entry_count    <= cnt5(r_occ);
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCW'(DEPTH))
        else $error("occupancy above depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_ok |=> r_occ == $past(r_occ) - OCW'(1))
        else $error("pop did not drop occupancy by one");

    a_sweep_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sweep |-> (r_left != '0) && (r_left <= r_occ + OCW'(r_found)))
        else $error("sweep count out of step with occupancy");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> (r_out.status == STAT_OK))
        else $error("found result without ok status");

    a_single_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sweep && r_found) |-> !w_drop)
        else $error("second removal in one sweep");
`endif

endmodule

>>> hdl/fqsr_cell.sv
module fqsr_cell
    import fqsr_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_load_data,
    input  logic [DATA_W-1:0] i_next_data,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;

    // load wins over shift: the tail cell of a rotation takes the head value
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_data <= i_load_data;
        end else if (i_ctrl.shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

>>> tb/fqsr_queue_checker.sv
module fqsr_queue_checker
    import fqsr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    logic [31:0] shadow_slots [DEPTH];
    int          shadow_count;
    t_out        pending_results [$];
    int          fail_total;

    // drop one entry, later entries move one place toward the head
    function automatic void drop_slot(int pos);
        int k;
        for (k = pos; k + 1 < shadow_count; k++) begin
            shadow_slots[k] = shadow_slots[k + 1];
        end
        shadow_count--;
    endfunction

    function automatic t_out queue_apply(t_in item);
        t_out r;
        int   hit;
        int   k;
        r        = '0;
        r.status = STAT_OK;
        hit      = -1;
        for (k = 0; k < shadow_count; k++) begin
            if (hit < 0 && shadow_slots[k] == item.value) begin
                hit = k;
            end
        end
        case (item.cmd)
            CMD_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    shadow_slots[shadow_count] = item.value;
                    shadow_count++;
                end
            end
            CMD_POP: begin
                if (shadow_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.popped_value = shadow_slots[0];
                    drop_slot(0);
                end
            end
            default: begin
                if (hit < 0) begin
                    r.status = STAT_MISSING;
                end else begin
                    r.found          = 1'b1;
                    r.match_position = 4'(hit);
                    if (item.cmd == CMD_REMOVE) begin
                        drop_slot(hit);
                    end
                end
            end
        endcase
        r.entry_count = 5'(shadow_count);
        return r;
    endfunction

    function automatic int field_differs(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        int   bad;
        if (!i_rst_n) begin
            shadow_count = 0;
            pending_results.delete();
        end else begin
            // result first: the output is registered, so it belongs to an older item
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, i_out_data);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    bad  = 0;
                    bad += field_differs("status", 32'(want.status),
                                         32'(i_out_data.status));
                    bad += field_differs("popped_value", want.popped_value,
                                         i_out_data.popped_value);
                    bad += field_differs("found", 32'(want.found), 32'(i_out_data.found));
                    bad += field_differs("match_position", 32'(want.match_position),
                                         32'(i_out_data.match_position));
                    bad += field_differs("entry_count", 32'(want.entry_count),
                                         32'(i_out_data.entry_count));
                    if (bad != 0) begin
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(queue_apply(i_in_data));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_results.size();
    end

endmodule

>>> tb/tb_top.sv
module tb_top;
    import fqsr_pkg::*;

    localparam int DEPTH            = 16;
    localparam int RANDOM_PER_PHASE = 475;
    localparam int HOLD_CYCLES      = 80;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    int   fail_count;
    int   pending;

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    logic [31:0] pool [8];

    fifo_queue_with_search_and_remove_core #(.DEPTH(DEPTH)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    fqsr_queue_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #3000000;
        $display("fifo_queue_with_search_and_remove_core regression: fail");
        $finish;
    end

    // receiver: random stall, or a long hold-off once on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    function automatic t_in mk(t_cmd c, logic [31:0] v);
        t_in item;
        item.cmd   = c;
        item.value = v;
        return item;
    endfunction

    // mostly pooled values so that searches and removes hit
    function automatic t_in random_item(int push_bias);
        t_cmd        c;
        logic [31:0] v;
        if ($urandom_range(0, 99) < push_bias) begin
            c = CMD_PUSH;
        end else begin
            c = t_cmd'($urandom_range(1, 3));
        end
        if ($urandom_range(0, 99) < 60) begin
            v = pool[$urandom_range(0, 7)];
        end else begin
            v = $urandom;
        end
        return mk(c, v);
    endfunction

    // called just after a falling edge; returns just after one
    task automatic send_item(t_in item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        int ph;
        int n;
        int k;
        int push_bias;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h7FFF_FFFF;
        for (k = 4; k < 8; k++) begin
            pool[k] = $urandom;
        end
        push_bias = 50;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue cases, then removing the only entry
        send_item(mk(CMD_POP, 32'h0));
        send_item(mk(CMD_SEARCH, 32'h5));
        send_item(mk(CMD_PUSH, 32'h7));
        send_item(mk(CMD_REMOVE, 32'h7));
        send_item(mk(CMD_PUSH, 32'h8000_0000));
        send_item(mk(CMD_PUSH, 32'h7FFF_FFFF));
        send_item(mk(CMD_PUSH, 32'h0));
        send_item(mk(CMD_PUSH, 32'hFFFF_FFFF));
        send_item(mk(CMD_SEARCH, 32'h7FFF_FFFF));
        send_item(mk(CMD_REMOVE, 32'h0));
        send_item(mk(CMD_REMOVE, 32'h1234));
        // fill up, with duplicates of the top value
        for (k = 0; k < 13; k++) begin
            send_item(mk(CMD_PUSH, (k % 2) ? 32'h7FFF_FFFF : 32'h100 + k));
        end
        send_item(mk(CMD_PUSH, 32'hDEAD_BEEF));
        send_item(mk(CMD_SEARCH, 32'h10C));
        send_item(mk(CMD_REMOVE, 32'h7FFF_FFFF));
        send_item(mk(CMD_POP, 32'hFFFF_FFFF));
        wait_drain();

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct  = 20;
                    rx_stall_pct = 78;
                end
                1: begin
                    tx_idle_pct  = 78;
                    rx_stall_pct = 20;
                end
                default: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_req     = 1'b1;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                // swing between filling and draining so both ends are reached
                if (n % 60 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_bias = 15;
                        1:       push_bias = 45;
                        default: push_bias = 85;
                    endcase
                end
                if ($urandom_range(0, 19) == 0) begin
                    pool[$urandom_range(0, 7)] = $urandom;
                end
                send_item(random_item(push_bias));
            end
            wait_drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("fifo_queue_with_search_and_remove_core regression: pass");
        end else begin
            $display("fifo_queue_with_search_and_remove_core regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/fqsr_pkg.sv
hdl/fqsr_cell.sv
hdl/fifo_queue_with_search_and_remove_core.sv
tb/fqsr_queue_checker.sv
tb/tb_top.sv
